// ===== sv/dles_pkg.sv =====
// shared types, codes and constants for the delta list event scheduler
`default_nettype none

package dles_pkg;

  // command codes
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_ADVANCE  = 2'd2;

  // code reported for the idle tail event
  localparam logic [3:0] IDLE_CODE = 4'd15;

  // pops per advance before the scheduler hands control back
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 4;

  // reset value of the idle period register
  localparam logic [15:0] IDLE_RESET = 16'h4000;

  // one command transfer
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  event_id;
    logic [30:0] delay;
    logic [13:0] elapsed;
  } cmd_t;

  // one result transfer
  typedef struct packed {
    logic [3:0]  fired_event;
    logic        last_fired;
    logic [31:0] current_cycle;
  } result_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UL_READ,
    ST_UL_NEXT,
    ST_UL_SUM,
    ST_UL_WALK,
    ST_INS_GO,
    ST_INS_WALK,
    ST_INS_PLACE,
    ST_INS_FIX,
    ST_ADV_CHK,
    ST_POP,
    ST_POP_LINK,
    ST_POP_END
  } state_t;

  // countdown is tested as a signed value
  function automatic logic is_positive(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dles_store.sv =====
// delta and link memories of the event list, one read address, registered read data
`default_nettype none

module dles_store #(
  parameter int NUM_EVENTS = 16,
  localparam int IW = $clog2(NUM_EVENTS)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output logic [31:0]        delta_rd,
  output logic [IW-1:0]      link_rd,
  input  wire logic          delta_we,
  input  wire logic [IW-1:0] delta_waddr,
  input  wire logic [31:0]   delta_wdata,
  input  wire logic          link_we,
  input  wire logic [IW-1:0] link_waddr,
  input  wire logic [IW-1:0] link_wdata
);

  logic [31:0]   delta_mem [NUM_EVENTS];
  logic [IW-1:0] link_mem  [NUM_EVENTS];

  // delta memory
  always_ff @(posedge clk) begin
    if (delta_we) begin
      delta_mem[delta_waddr] <= delta_wdata;
    end
    if (rd_en) begin
      delta_rd <= delta_mem[rd_addr];
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dles_seq.sv =====
// sequencer: list walks for schedule and cancel, pops for advance, head registers
`default_nettype none

module dles_seq #(
  parameter int NUM_EVENTS = 16,
  localparam int IW = $clog2(NUM_EVENTS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [15:0]      idle_period,
  input  wire logic             start,
  input  wire dles_pkg::cmd_t   cmd,
  output logic                  busy,
  output logic                  done,
  output dles_pkg::result_t     result,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  wire logic [31:0]      delta_rd,
  input  wire logic [IW-1:0]    link_rd,
  output logic                  delta_we,
  output logic [IW-1:0]         delta_waddr,
  output logic [31:0]           delta_wdata,
  output logic                  link_we,
  output logic [IW-1:0]         link_waddr,
  output logic [IW-1:0]         link_wdata
);

  localparam logic [IW-1:0] IDLE_ID = IW'(NUM_EVENTS - 1);
  localparam logic [dles_pkg::CNT_W-1:0] LAST_CNT =
    dles_pkg::CNT_W'(dles_pkg::MAX_RESULTS - 1);

  dles_pkg::state_t state, state_next;

  // list state
  logic [NUM_EVENTS-1:0] pending;
  logic [IW-1:0]         head;
  logic [31:0]           dur;
  logic [31:0]           cd;
  logic [31:0]           cc;
  logic [15:0]           idle_delta;
  logic [dles_pkg::CNT_W-1:0] cnt;

  // per command working registers
  logic [1:0]    op_r;
  logic [IW-1:0] n_r;
  logic [30:0]   t_r;
  logic [31:0]   dn_r;
  logic [IW-1:0] nx_r;
  logic [IW-1:0] cur_r;
  logic [IW-1:0] prev_r;
  logic          has_prev;
  logic [31:0]   run_r;
  logic [31:0]   dcur_r;
  logic [IW-1:0] nh_r;

  // shared combinational terms
  logic          accept;
  logic          id_ok;
  logic [IW-1:0] cmd_n;
  logic [31:0]   t_ext;
  logic [31:0]   nx_sum;
  logic          ul_head;
  logic          ul_found;
  logic          ul_done;
  logic          ins_stop;
  logic [31:0]   dn_new;
  logic [31:0]   pop_dnew;
  logic [31:0]   pop_cd;
  logic          pop_last;

  assign accept   = start && (state == dles_pkg::ST_IDLE);
  assign id_ok    = (32'(cmd.event_id) < 32'(NUM_EVENTS - 1)) &&
                    (cmd.event_id != dles_pkg::IDLE_CODE);
  assign cmd_n    = IW'(cmd.event_id);
  assign t_ext    = {1'b0, t_r};
  assign nx_sum   = ((nx_r == IDLE_ID) ? 32'(idle_delta) : delta_rd) + dn_r;
  assign ul_head  = (head == n_r);
  assign ul_found = (link_rd == n_r) || (link_rd == IDLE_ID);
  assign ul_done  = ((state == dles_pkg::ST_UL_SUM) && ul_head) ||
                    ((state == dles_pkg::ST_UL_WALK) && ul_found);
  assign ins_stop = (run_r + delta_rd) > t_ext;
  assign dn_new   = t_ext - run_r;
  assign pop_dnew = (nh_r == IDLE_ID) ? 32'(idle_delta) : delta_rd;
  assign pop_cd   = cd + pop_dnew;
  assign pop_last = dles_pkg::is_positive(pop_cd) || (cnt == LAST_CNT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dles_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            dles_pkg::OP_SCHEDULE: begin
              if (id_ok) begin
                state_next = pending[cmd_n] ? dles_pkg::ST_UL_READ : dles_pkg::ST_INS_GO;
              end
            end
            dles_pkg::OP_CANCEL: begin
              if (id_ok && pending[cmd_n]) begin
                state_next = dles_pkg::ST_UL_READ;
              end
            end
            dles_pkg::OP_ADVANCE: state_next = dles_pkg::ST_ADV_CHK;
            default: state_next = dles_pkg::ST_IDLE;
          endcase
        end
      end
      dles_pkg::ST_UL_READ: state_next = dles_pkg::ST_UL_NEXT;
      dles_pkg::ST_UL_NEXT: state_next = dles_pkg::ST_UL_SUM;
      dles_pkg::ST_UL_SUM, dles_pkg::ST_UL_WALK: begin
        if (ul_done) begin
          state_next = (op_r == dles_pkg::OP_SCHEDULE) ? dles_pkg::ST_INS_GO
                                                       : dles_pkg::ST_IDLE;
        end else begin
          state_next = dles_pkg::ST_UL_WALK;
        end
      end
      dles_pkg::ST_INS_GO: begin
        state_next = (head == IDLE_ID) ? dles_pkg::ST_INS_PLACE : dles_pkg::ST_INS_WALK;
      end
      dles_pkg::ST_INS_WALK: begin
        if (ins_stop || (link_rd == IDLE_ID)) begin
          state_next = dles_pkg::ST_INS_PLACE;
        end
      end
      dles_pkg::ST_INS_PLACE: state_next = dles_pkg::ST_INS_FIX;
      dles_pkg::ST_INS_FIX:   state_next = dles_pkg::ST_IDLE;
      dles_pkg::ST_ADV_CHK: begin
        state_next = dles_pkg::is_positive(cd) ? dles_pkg::ST_IDLE : dles_pkg::ST_POP;
      end
      dles_pkg::ST_POP: begin
        state_next = (head == IDLE_ID) ? dles_pkg::ST_POP_END : dles_pkg::ST_POP_LINK;
      end
      dles_pkg::ST_POP_LINK: state_next = dles_pkg::ST_POP_END;
      dles_pkg::ST_POP_END: begin
        state_next = pop_last ? dles_pkg::ST_IDLE : dles_pkg::ST_POP;
      end
      default: state_next = dles_pkg::ST_IDLE;
    endcase
  end

  // memory accesses and busy
  always_comb begin
    busy        = (state != dles_pkg::ST_IDLE);
    rd_en       = 1'b0;
    rd_addr     = head;
    delta_we    = 1'b0;
    delta_waddr = n_r;
    delta_wdata = dn_new;
    link_we     = 1'b0;
    link_waddr  = n_r;
    link_wdata  = cur_r;
    unique case (state)
      dles_pkg::ST_UL_READ: begin
        rd_en   = 1'b1;
        rd_addr = n_r;
      end
      dles_pkg::ST_UL_NEXT: begin
        rd_en   = (link_rd != IDLE_ID);
        rd_addr = link_rd;
      end
      dles_pkg::ST_UL_SUM: begin
        delta_we    = (nx_r != IDLE_ID);
        delta_waddr = nx_r;
        delta_wdata = nx_sum;
        rd_en       = !ul_head;
        rd_addr     = head;
      end
      dles_pkg::ST_UL_WALK: begin
        if (link_rd == n_r) begin
          link_we    = 1'b1;
          link_waddr = cur_r;
          link_wdata = nx_r;
        end else begin
          rd_en   = (link_rd != IDLE_ID);
          rd_addr = link_rd;
        end
      end
      dles_pkg::ST_INS_GO: begin
        rd_en   = (head != IDLE_ID);
        rd_addr = head;
      end
      dles_pkg::ST_INS_WALK: begin
        rd_en   = !ins_stop && (link_rd != IDLE_ID);
        rd_addr = link_rd;
      end
      dles_pkg::ST_INS_PLACE: begin
        delta_we    = 1'b1;
        delta_waddr = n_r;
        delta_wdata = dn_new;
        link_we     = 1'b1;
        link_waddr  = n_r;
        link_wdata  = cur_r;
      end
      dles_pkg::ST_INS_FIX: begin
        delta_we    = (cur_r != IDLE_ID);
        delta_waddr = cur_r;
        delta_wdata = dcur_r - dn_r;
        link_we     = has_prev;
        link_waddr  = prev_r;
        link_wdata  = n_r;
      end
      dles_pkg::ST_POP: begin
        rd_en   = (head != IDLE_ID);
        rd_addr = head;
      end
      dles_pkg::ST_POP_LINK: begin
        rd_en   = (link_rd != IDLE_ID);
        rd_addr = link_rd;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // list state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dles_pkg::ST_IDLE;
      pending    <= '0;
      head       <= IDLE_ID;
      dur        <= 32'(dles_pkg::IDLE_RESET);
      cd         <= 32'(dles_pkg::IDLE_RESET);
      cc         <= 32'd0;
      idle_delta <= dles_pkg::IDLE_RESET;
      cnt        <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept && (cmd.opcode == dles_pkg::OP_ADVANCE)) begin
        cd <= cd - 32'(cmd.elapsed);
      end
      // unlink finished
      if (ul_done) begin
        pending[n_r] <= 1'b0;
        idle_delta   <= idle_period;
      end
      if ((state == dles_pkg::ST_UL_SUM) && ul_head) begin
        head <= nx_r;
        dur  <= nx_sum;
        cd   <= nx_sum - (dur - cd);
      end
      // insert lands
      if (state == dles_pkg::ST_INS_PLACE) begin
        pending[n_r] <= 1'b1;
        idle_delta   <= idle_period;
        if (!has_prev) begin
          head <= n_r;
          dur  <= dn_new;
          cd   <= t_ext;
        end
      end
      if (state == dles_pkg::ST_ADV_CHK) begin
        cnt <= '0;
      end
      // one pop per pass
      if (state == dles_pkg::ST_POP_END) begin
        if (head != IDLE_ID) begin
          pending[head] <= 1'b0;
        end
        cc   <= cc + dur;
        head <= nh_r;
        dur  <= pop_dnew;
        cd   <= pop_cd;
        cnt  <= cnt + 1'b1;
        done <= 1'b1;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= cmd.opcode;
      n_r  <= cmd_n;
      t_r  <= cmd.delay;
    end
    unique case (state)
      dles_pkg::ST_UL_NEXT: begin
        dn_r <= delta_rd;
        nx_r <= link_rd;
      end
      dles_pkg::ST_UL_SUM: begin
        cur_r <= head;
      end
      dles_pkg::ST_UL_WALK: begin
        if (!ul_found) begin
          cur_r <= link_rd;
        end
      end
      dles_pkg::ST_INS_GO: begin
        run_r    <= cd - dur;
        cur_r    <= head;
        has_prev <= 1'b0;
      end
      dles_pkg::ST_INS_WALK: begin
        if (ins_stop) begin
          dcur_r <= delta_rd;
        end else begin
          run_r    <= run_r + delta_rd;
          prev_r   <= cur_r;
          has_prev <= 1'b1;
          cur_r    <= link_rd;
        end
      end
      dles_pkg::ST_INS_PLACE: begin
        dn_r <= dn_new;
      end
      dles_pkg::ST_POP: begin
        nh_r <= IDLE_ID;
      end
      dles_pkg::ST_POP_LINK: begin
        nh_r <= link_rd;
      end
      dles_pkg::ST_POP_END: begin
        result.fired_event   <= (head == IDLE_ID) ? dles_pkg::IDLE_CODE : 4'(head);
        result.last_fired    <= pop_last;
        result.current_cycle <= cc + dur;
      end
      default: begin
        nh_r <= nh_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/delta_list_event_scheduler_top.sv =====
// top level of the delta list event scheduler: config register, sequencer, list memories
//
// Usage: a command transfer is taken at a clock edge where start is high and
// busy is low. cmd carries opcode, event_id, delay and elapsed. Schedule
// removes the event if pending and inserts it by delay; cancel unlinks it;
// advance counts the head down and pops the due events, at most MAX_RESULTS
// per command. Each popped event shows on result with done high for exactly
// one cycle; the receiver cannot stall, so results simply stream out,
// last_fired marking the final one. One command at a time: schedule walks
// the list to unlink the event if pending, then walks it again to find the
// insert place; cancel does the unlink walk alone; advance checks the
// countdown and, if due, pops one event per pass. The walk is bound by one
// memory read per node, each next address coming from the link just read.
// idle_period is written through cfg_we/cfg_wdata; the user must write it
// only while busy is low, the block itself does not enforce this.
// Reset (rst, synchronous) empties the list, leaves only the idle event at
// the head with idle period 0x4000 and clears the cycle counter; no memory
// clearing pass is needed.
`default_nettype none

module delta_list_event_scheduler_top #(
  parameter int NUM_EVENTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              start,
  input  wire dles_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output dles_pkg::result_t      result
);

  localparam int IW = $clog2(NUM_EVENTS);

  logic [15:0]   idle_period;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   delta_rd;
  logic [IW-1:0] link_rd;
  logic          delta_we;
  logic [IW-1:0] delta_waddr;
  logic [31:0]   delta_wdata;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;

  // idle period register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_period <= dles_pkg::IDLE_RESET;
    end else if (cfg_we) begin
      idle_period <= cfg_wdata;
    end
  end

  dles_seq #(.NUM_EVENTS(NUM_EVENTS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .idle_period (idle_period),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .delta_rd    (delta_rd),
    .link_rd     (link_rd),
    .delta_we    (delta_we),
    .delta_waddr (delta_waddr),
    .delta_wdata (delta_wdata),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata)
  );

  dles_store #(.NUM_EVENTS(NUM_EVENTS)) u_store (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .delta_rd    (delta_rd),
    .link_rd     (link_rd),
    .delta_we    (delta_we),
    .delta_waddr (delta_waddr),
    .delta_wdata (delta_wdata),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata)
  );

endmodule

`default_nettype wire
